>>> rtl/core/swap_slot_bitmap_allocator_assert.svh
// ---------------------------------------------------------------------------
// swap slot bitmap allocator assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// check gated off while reset is asserted
`define SSBA_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// check that also holds through reset
`define SSBA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`else

`define SSBA_ASSERT(lbl, ck, rstn, prop, msg)
`define SSBA_ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

>>> rtl/core/ssba_pkg.sv
// ---------------------------------------------------------------------------
// ssba_pkg
// shared types, widths and helper functions of the swap slot allocator
// ---------------------------------------------------------------------------
`default_nettype none

package ssba_pkg;

	localparam int MAX_SLOTS        = 1024;
	localparam int SECTORS_PER_SLOT = 8;

	localparam int SLOT_W = 10;
	localparam int CNT_W  = 11;
	localparam int SEC_W  = 13;

	// bitmap memory geometry
	localparam int WORD_W  = 32;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int WORDS   = MAX_SLOTS / WORD_W;
	localparam int WADDR_W = $clog2(WORDS);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_USED = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_MOD
	} state_t;

	typedef struct packed {
		logic               en;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  word;
	} map_wr_t;

	// position of the lowest clear bit, zero when none
	function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) pos = BIT_W'(i);
		end
		return pos;
	endfunction

	// position of the lowest set bit, zero when none
	function automatic logic [WADDR_W-1:0] lowest_set(input logic [WORDS-1:0] v);
		logic [WADDR_W-1:0] pos;
		pos = '0;
		for (int i = WORDS - 1; i >= 0; i--) begin
			if (v[i]) pos = WADDR_W'(i);
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/ssba_map.sv
// ---------------------------------------------------------------------------
// ssba_map
// used/free bitmap held as words in a synchronous memory, with a per-word
// written flag standing in for the reset clear and a per-word free summary
// ---------------------------------------------------------------------------
`default_nettype none

module ssba_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [ssba_pkg::WADDR_W-1:0] rd_addr,
	output logic [ssba_pkg::WORD_W-1:0]  rd_word,
	input  ssba_pkg::map_wr_t            wr,
	output logic [ssba_pkg::WORDS-1:0]   free_words
);
	import ssba_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic              rvalid_q;
	logic [WORDS-1:0]  valid_q;
	logic [WORDS-1:0]  free_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.word;
		end
		if (rd_en) begin
			rdata_q  <= mem[rd_addr];
			rvalid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			free_q  <= '1;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
			free_q[wr.addr]  <= ~&wr.word;
		end
	end

	// a word never written reads as all free
	assign rd_word    = rvalid_q ? rdata_q : '0;
	assign free_words = free_q;

endmodule

`default_nettype wire

>>> rtl/core/swap_slot_bitmap_allocator.sv
// ---------------------------------------------------------------------------
// swap_slot_bitmap_allocator
// first-fit swap slot allocator over a used/free bitmap
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low, in S_IDLE. It then
// passes through S_READ, which reads a 32-slot word of the bitmap memory
// (the free-word summary picks the word for an allocate, the slot index picks
// it for a release), and S_MOD, the read-modify-write. The result shows on
// status, slot and first_sector for exactly one cycle with done high, in the
// cycle after the write; busy is already low then, so the next item can be
// started in that same cycle. The result must be taken when done is high;
// there is no hold-off. The bitmap is free after reset with no clearing pass.
// slot_count is written with cfg_we while the block is idle, a rule for the
// user that the block does not enforce; values above 1024 act as 1024.
// ---------------------------------------------------------------------------
`default_nettype none

`include "swap_slot_bitmap_allocator_assert.svh"

module swap_slot_bitmap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [ssba_pkg::SLOT_W-1:0] slot_index,
	input  logic                        cfg_we,
	input  logic [ssba_pkg::CNT_W-1:0]  cfg_data,
	output logic                        done,
	output ssba_pkg::status_t           status,
	output logic [ssba_pkg::SLOT_W-1:0] slot,
	output logic [ssba_pkg::SEC_W-1:0]  first_sector
);
	import ssba_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   slot_count_q;
	cmd_t               cmd_s1;
	logic [SLOT_W-1:0]  idx_s1;
	logic [WADDR_W-1:0] word_addr_s2;
	logic               cand_any_s2;
	logic               done_q;
	status_t            status_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SEC_W-1:0]   sector_q;

	logic               accept;
	logic               rd_en;
	logic [WADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0]  rd_word;
	logic [WORDS-1:0]   free_words;
	map_wr_t            wr;

	logic [CNT_W-1:0]   n_eff;
	logic [CNT_W-1:0]   words_lim;
	logic [WORDS-1:0]   avail;
	logic [WADDR_W-1:0] cand_addr;
	logic               write_ok;
	status_t            res_status;
	logic [SLOT_W-1:0]  res_slot;
	logic [WORD_W-1:0]  new_word;
	logic [BIT_W-1:0]   free_pos;
	logic [SLOT_W-1:0]  alloc_slot;
	logic [BIT_W-1:0]   rel_pos;

	ssba_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_word    (rd_word),
		.wr         (wr),
		.free_words (free_words)
	);

	assign accept = start && !busy;

	// usable count and the free words that hold at least one usable slot
	always_comb begin
		n_eff     = (slot_count_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_q;
		words_lim = CNT_W'((n_eff + CNT_W'(WORD_W - 1)) >> BIT_W);
		for (int w = 0; w < WORDS; w++) begin
			avail[w] = free_words[w] && (CNT_W'(w) < words_lim);
		end
		cand_addr = lowest_set(avail);
	end

	// read-modify-write of the fetched word
	always_comb begin
		free_pos   = lowest_zero(rd_word);
		alloc_slot = SLOT_W'({word_addr_s2, free_pos});
		rel_pos    = idx_s1[BIT_W-1:0];
		new_word   = rd_word;
		res_status = ST_OK;
		res_slot   = '0;
		write_ok   = 1'b0;
		unique case (cmd_s1)
			CMD_ALLOC: begin
				if (cand_any_s2 && (CNT_W'(alloc_slot) < n_eff)) begin
					new_word[free_pos] = 1'b1;
					res_slot           = alloc_slot;
					write_ok           = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			CMD_RELEASE: begin
				priority if (CNT_W'(idx_s1) >= n_eff) begin
					res_status = ST_RANGE;
				end else if (!rd_word[rel_pos]) begin
					res_status = ST_NOT_USED;
				end else begin
					new_word[rel_pos] = 1'b0;
					res_slot          = idx_s1;
					write_ok          = 1'b1;
				end
			end
			default: res_status = ST_RANGE;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_READ;
			S_READ:  state_d = S_MOD;
			S_MOD:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy    = 1'b0;
		rd_en   = 1'b0;
		rd_addr = (cmd_s1 == CMD_ALLOC) ? cand_addr : idx_s1[BIT_W +: WADDR_W];
		wr.en   = 1'b0;
		wr.addr = word_addr_s2;
		wr.word = new_word;
		unique case (state_q)
			S_IDLE: ;
			S_READ: begin
				busy  = 1'b1;
				rd_en = 1'b1;
			end
			S_MOD: begin
				busy  = 1'b1;
				wr.en = write_ok;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_count_q <= CNT_W'(MAX_SLOTS);
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_MOD);
			if (cfg_we) begin
				slot_count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(cmd);
			idx_s1 <= slot_index;
		end
		if (state_q == S_READ) begin
			word_addr_s2 <= rd_addr;
			cand_any_s2  <= |avail;
		end
		if (state_q == S_MOD) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			sector_q <= SEC_W'(SEC_W'(res_slot) * SEC_W'(SECTORS_PER_SLOT));
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign first_sector = sector_q;

	`SSBA_ASSERT(a_beat_latency, clk, arst_n, (start && !busy) |-> ##3 done,
		"accepted beat did not produce a result three cycles later")
	`SSBA_ASSERT(a_fail_zero, clk, arst_n,
		(done && status != ST_OK) |-> (slot == '0 && first_sector == '0),
		"failed result carries a nonzero slot or sector")
	`SSBA_ASSERT(a_write_in_range, clk, arst_n,
		wr.en |-> (CNT_W'({wr.addr, {BIT_W{1'b0}}}) < n_eff),
		"bitmap write to a word with no usable slot")
	`SSBA_ASSERT_ALWAYS(a_done_idle, clk, done |-> !busy,
		"result strobe while still busy")

endmodule

`default_nettype wire
